// ----- src/sdrpip_pkg.sv -----
package sdrpip_pkg;

    localparam logic [7:0]  HDR_BYTE0      = 8'hEF;
    localparam logic [7:0]  HDR_BYTE1      = 8'hFE;
    localparam logic [7:0]  TYPE_DATA      = 8'h01;
    localparam logic [7:0]  TYPE_DISCOVERY = 8'h02;
    localparam logic [7:0]  TYPE_STARTSTOP = 8'h04;
    localparam logic [7:0]  SYNC_BYTE      = 8'h7F;
    localparam logic [4:0]  FREQ_ADDR      = 5'h02;

    localparam logic [10:0] POS_MAX        = 11'd2047;
    localparam logic [10:0] HEADER_BYTES   = 11'd8;
    localparam logic [10:0] PACKET_BYTES   = 11'd1032;

    localparam logic        REC_SAMPLE     = 1'b0;
    localparam logic        REC_SUMMARY    = 1'b1;

    localparam logic [2:0]  KIND_UNKNOWN   = 3'd0;
    localparam logic [2:0]  KIND_DISCOVERY = 3'd1;
    localparam logic [2:0]  KIND_START     = 3'd2;
    localparam logic [2:0]  KIND_STOP      = 3'd3;
    localparam logic [2:0]  KIND_DATA      = 3'd4;

    // one queue entry: everything one input byte produces
    typedef struct packed {
        logic        has_sample;
        logic [15:0] i_sample;
        logic [15:0] q_sample;
        logic        has_summary;
        logic [2:0]  packet_kind;
        logic        mox_flag;
        logic [31:0] frequency_word;
        logic [6:0]  sample_total;
    } entry_t;

    typedef struct packed {
        logic push;
        logic pop;
    } q_ctrl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ----- src/sdrpip_front.sv -----
module sdrpip_front #(
    parameter int MAX_SAMPLES = 126
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  logic [7:0]            data_byte,
    input  logic                  end_of_packet,
    input  logic                  q_full,
    output logic                  in_ready,
    output logic                  push,
    output sdrpip_pkg::entry_t    push_entry
);

    logic [10:0] pos_reg, pos_next;
    logic        hdr_good_reg, hdr_good_next;
    logic [7:0]  type_reg, type_next;
    logic        start_reg, start_next;
    logic        sync_reg, sync_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic        mox_reg, mox_next;
    logic [31:0] freq_reg, freq_next;
    logic [31:0] stage_reg, stage_next;
    logic [6:0]  seen_reg, seen_next;

    logic        accept;
    logic        in_body;
    logic [10:0] rel;
    logic        frame;
    logic [8:0]  ofs;
    logic [31:0] shifted;
    logic        fire;
    logic [2:0]  kind;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;

    assign in_body = (pos_reg >= sdrpip_pkg::HEADER_BYTES) &&
                     (pos_reg < sdrpip_pkg::PACKET_BYTES);
    assign rel     = pos_reg - sdrpip_pkg::HEADER_BYTES;
    assign frame   = rel[9];
    assign ofs     = rel[8:0];
    assign shifted = {stage_reg[23:0], data_byte};

    always_comb begin
        hdr_good_next = hdr_good_reg;
        type_next     = type_reg;
        start_next    = start_reg;
        sync_next     = sync_reg;
        cmd_next      = cmd_reg;
        mox_next      = mox_reg;
        freq_next     = freq_reg;
        stage_next    = stage_reg;
        seen_next     = seen_reg;
        fire          = 1'b0;

        case (pos_reg)
            11'd0: hdr_good_next = (data_byte == sdrpip_pkg::HDR_BYTE0);
            11'd1: hdr_good_next = hdr_good_reg && (data_byte == sdrpip_pkg::HDR_BYTE1);
            11'd2: type_next     = data_byte;
            11'd3: start_next    = data_byte[0];
            default: ;
        endcase

        if (in_body) begin
            if (ofs == 9'd0) begin
                sync_next = (data_byte == sdrpip_pkg::SYNC_BYTE);
            end else if (ofs <= 9'd2) begin
                sync_next = sync_reg && (data_byte == sdrpip_pkg::SYNC_BYTE);
            end else if (ofs == 9'd3) begin
                cmd_next = data_byte;
                if (!frame) begin
                    mox_next = sync_reg && data_byte[0];
                end
            end else if (ofs <= 9'd7) begin
                stage_next = shifted;
                if (ofs == 9'd7 && sync_reg && cmd_reg[5:1] == sdrpip_pkg::FREQ_ADDR) begin
                    freq_next = shifted;
                end
            end else if (ofs[2]) begin
                // slot bytes 4..7 carry I then Q, big-endian
                stage_next = shifted;
                if (ofs[1:0] == 2'd3 && sync_reg && hdr_good_reg &&
                    type_reg == sdrpip_pkg::TYPE_DATA &&
                    seen_reg < 7'(MAX_SAMPLES)) begin
                    fire      = 1'b1;
                    seen_next = seen_reg + 7'd1;
                end
            end
        end

        pos_next = (pos_reg < sdrpip_pkg::POS_MAX) ? pos_reg + 11'd1 : pos_reg;

        kind = sdrpip_pkg::KIND_UNKNOWN;
        if (pos_reg >= 11'd3 && hdr_good_next) begin
            if (type_next == sdrpip_pkg::TYPE_DISCOVERY) begin
                kind = sdrpip_pkg::KIND_DISCOVERY;
            end else if (type_next == sdrpip_pkg::TYPE_STARTSTOP) begin
                kind = start_next ? sdrpip_pkg::KIND_START : sdrpip_pkg::KIND_STOP;
            end else if (type_next == sdrpip_pkg::TYPE_DATA &&
                         pos_reg >= sdrpip_pkg::PACKET_BYTES - 11'd1) begin
                kind = sdrpip_pkg::KIND_DATA;
            end
        end

        push_entry.has_sample     = fire;
        push_entry.i_sample       = shifted[31:16];
        push_entry.q_sample       = shifted[15:0];
        push_entry.has_summary    = end_of_packet;
        push_entry.packet_kind    = kind;
        push_entry.mox_flag       = (kind == sdrpip_pkg::KIND_DATA) && mox_next;
        push_entry.frequency_word = (kind == sdrpip_pkg::KIND_DATA) ? freq_next : 32'd0;
        push_entry.sample_total   = (kind == sdrpip_pkg::KIND_DATA) ? seen_next : 7'd0;
    end

    assign push = accept && (fire || end_of_packet);

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && end_of_packet)) begin
            pos_reg      <= '0;
            hdr_good_reg <= 1'b0;
            type_reg     <= '0;
            start_reg    <= 1'b0;
            sync_reg     <= 1'b0;
            cmd_reg      <= '0;
            mox_reg      <= 1'b0;
            freq_reg     <= '0;
            stage_reg    <= '0;
            seen_reg     <= '0;
        end else if (accept) begin
            pos_reg      <= pos_next;
            hdr_good_reg <= hdr_good_next;
            type_reg     <= type_next;
            start_reg    <= start_next;
            sync_reg     <= sync_next;
            cmd_reg      <= cmd_next;
            mox_reg      <= mox_next;
            freq_reg     <= freq_next;
            stage_reg    <= stage_next;
            seen_reg     <= seen_next;
        end
    end

endmodule

// ----- src/sdrpip_fifo.sv -----
module sdrpip_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sdrpip_pkg::q_ctrl_t   ctrl,
    input  sdrpip_pkg::entry_t    wr_entry,
    output sdrpip_pkg::q_stat_t   stat,
    output sdrpip_pkg::entry_t    rd_entry
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

    sdrpip_pkg::entry_t slots_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = ctrl.push && !stat.full;
    assign do_pop     = ctrl.pop && !stat.empty;
    assign rd_entry   = slots_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + CW'(1);
                2'b01:   count_reg <= count_reg - CW'(1);
                default: ;
            endcase
        end
    end

endmodule

// ----- src/sdrpip_back.sv -----
module sdrpip_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sdrpip_pkg::entry_t    rd_entry,
    input  logic                  q_empty,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [79:0]           m_tdata,
    output logic                  m_tuser,
    output logic                  m_tlast
);

    sdrpip_pkg::entry_t cur_reg;
    logic pend_s_reg, pend_m_reg;
    logic beat, final_beat, load;

    assign m_tvalid   = pend_s_reg || pend_m_reg;
    assign beat       = m_tvalid && m_tready;
    assign final_beat = beat && !(pend_s_reg && pend_m_reg);
    assign load       = !m_tvalid || final_beat;
    assign pop        = load && !q_empty;

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= rd_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_s_reg <= 1'b0;
            pend_m_reg <= 1'b0;
        end else if (load) begin
            pend_s_reg <= pop && rd_entry.has_sample;
            pend_m_reg <= pop && rd_entry.has_summary;
        end else if (beat) begin
            // sample goes out first, summary of the same byte follows
            pend_s_reg <= 1'b0;
        end
    end

    always_comb begin
        if (pend_s_reg) begin
            m_tuser = sdrpip_pkg::REC_SAMPLE;
            m_tlast = !pend_m_reg;
            m_tdata = {5'd0, 7'd0, cur_reg.q_sample, cur_reg.i_sample, 32'd0, 1'b0,
                       sdrpip_pkg::KIND_DATA};
        end else begin
            m_tuser = sdrpip_pkg::REC_SUMMARY;
            m_tlast = 1'b1;
            m_tdata = {5'd0, cur_reg.sample_total, 16'd0, 16'd0, cur_reg.frequency_word,
                       cur_reg.mox_flag, cur_reg.packet_kind};
        end
    end

`ifndef SYNTHESIS
    a_summary_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == sdrpip_pkg::REC_SUMMARY) |-> m_tlast)
        else $error("summary beat without tlast");

    a_sample_then_summary: assert property (@(posedge aclk) disable iff (!aresetn)
        (beat && m_tuser == sdrpip_pkg::REC_SAMPLE && !m_tlast) |=>
        (m_tvalid && m_tuser == sdrpip_pkg::REC_SUMMARY))
        else $error("summary did not follow its sample");

    a_no_pop_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_s_reg && pend_m_reg) |-> !pop)
        else $error("queue popped while two beats still pending");

    a_sample_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == sdrpip_pkg::REC_SAMPLE) |->
        (m_tdata[2:0] == sdrpip_pkg::KIND_DATA && m_tdata[35:3] == 33'd0))
        else $error("sample beat with stray summary fields");
`endif

endmodule

// ----- src/sdr_packet_iq_parser.sv -----
// channel  | ports          | tdata (low bit up)                           | tuser       | tlast
// ---------+----------------+----------------------------------------------+-------------+--------------
// s_ input | s_tvalid/ready | data_byte[7:0]                               | -           | end_of_packet
// m_ out   | m_tvalid/ready | kind[2:0] mox[3] freq[35:4] i[51:36]         | record_type | last_of_run
//          |                | q[67:52] total[74:68], zero to [79]          |             |
//
// One byte per cycle while the queue is not full; the front updates packet state in the accept cycle.
// A byte's result enters the queue at its accepting edge, then the back end registers it and raises m_tvalid.
// A byte causing sample plus summary takes two output beats; the queue absorbs it.
// s_tready drops only when the FIFO_DEPTH-entry queue is full.
// aresetn is synchronous; the packet state resets and also clears after each tlast byte.
module sdr_packet_iq_parser #(
    parameter int MAX_SAMPLES = 126,
    parameter int FIFO_DEPTH  = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // packet_kind, mox_flag, frequency_word, i_sample,
                                   // q_sample, sample_total
    output logic        m_tuser,   // record_type
    output logic        m_tlast
);

    sdrpip_pkg::entry_t  push_entry, rd_entry;
    sdrpip_pkg::q_ctrl_t q_ctrl;
    sdrpip_pkg::q_stat_t q_stat;
    logic push, pop;

    assign q_ctrl.push = push;
    assign q_ctrl.pop  = pop;

    sdrpip_front #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .data_byte    (s_tdata),
        .end_of_packet(s_tlast),
        .q_full       (q_stat.full),
        .in_ready     (s_tready),
        .push         (push),
        .push_entry   (push_entry)
    );

    sdrpip_fifo #(
        .DEPTH(FIFO_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (q_ctrl),
        .wr_entry(push_entry),
        .stat    (q_stat),
        .rd_entry(rd_entry)
    );

    sdrpip_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_entry(rd_entry),
        .q_empty (q_stat.empty),
        .pop     (pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;

    localparam int N_SAMPLES_MAX = 126;
    localparam int N_ITEMS       = 1400;

    // one input beat as queued for the driver; hold = wait for all results first
    typedef struct {
        logic [7:0] data;
        logic       eop;
        bit         hold;
    } pkt_beat_t;

    typedef struct packed {
        logic        rtype;
        logic [2:0]  kind;
        logic        mox;
        logic [31:0] freq;
        logic [15:0] i_smp;
        logic [15:0] q_smp;
        logic [6:0]  total;
        logic        last;
    } iq_rec_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;    // data_byte[7:0]
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;          // kind, mox, freq, i, q, total, zero pad
    logic        m_tuser;          // record_type
    logic        m_tlast;

    pkt_beat_t tx_bytes_q[$];
    iq_rec_t   expected_recs[$];
    pkt_beat_t next_beat;
    int        n_bytes = 0;
    int        n_fail  = 0;
    int        cyc     = 0;
    logic      quiet;

    // parser state mirror
    logic [10:0] pos;
    logic        hdr_ok;
    logic [7:0]  type_code;
    logic        start_bit;
    logic        in_sync;
    logic [7:0]  c0;
    logic        mox_val;
    logic [31:0] freq_val;
    logic [31:0] stage;
    logic [6:0]  smp_cnt;

    sdr_packet_iq_parser #(.MAX_SAMPLES(N_SAMPLES_MAX)) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // long windows with no idling on either side
    assign quiet = (cyc % 3000) >= 2000;

    function automatic void clear_parser();
        pos       = '0;
        hdr_ok    = 1'b0;
        type_code = '0;
        start_bit = 1'b0;
        in_sync   = 1'b0;
        c0        = '0;
        mox_val   = 1'b0;
        freq_val  = '0;
        stage     = '0;
        smp_cnt   = '0;
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic eop);
        logic [10:0] p;
        logic [10:0] rel;
        logic [8:0]  o;
        logic [11:0] len;
        iq_rec_t     rec;
        p = pos;
        if (p == 0) begin
            hdr_ok = (b == sdrpip_pkg::HDR_BYTE0);
        end else if (p == 1) begin
            hdr_ok = hdr_ok && (b == sdrpip_pkg::HDR_BYTE1);
        end else if (p == 2) begin
            type_code = b;
        end else if (p == 3) begin
            start_bit = b[0];
        end
        if (p >= sdrpip_pkg::HEADER_BYTES && p < sdrpip_pkg::PACKET_BYTES) begin
            rel = p - sdrpip_pkg::HEADER_BYTES;
            o   = rel[8:0];
            if (o == 0) begin
                in_sync = (b == sdrpip_pkg::SYNC_BYTE);
            end else if (o <= 2) begin
                in_sync = in_sync && (b == sdrpip_pkg::SYNC_BYTE);
            end else if (o == 3) begin
                c0 = b;
                if (!rel[9])
                    mox_val = in_sync ? b[0] : 1'b0;
            end else if (o <= 7) begin
                stage = {stage[23:0], b};
                if (o == 7 && in_sync && c0[5:1] == sdrpip_pkg::FREQ_ADDR)
                    freq_val = stage;
            end else if (o[2]) begin
                // I then Q, big-endian, in the upper half of each slot
                stage = {stage[23:0], b};
                if (o[1:0] == 2'd3 && in_sync && hdr_ok &&
                    type_code == sdrpip_pkg::TYPE_DATA && smp_cnt < N_SAMPLES_MAX) begin
                    rec       = '0;
                    rec.rtype = sdrpip_pkg::REC_SAMPLE;
                    rec.kind  = sdrpip_pkg::KIND_DATA;
                    rec.i_smp = stage[31:16];
                    rec.q_smp = stage[15:0];
                    rec.last  = !eop;
                    expected_recs.push_back(rec);
                    smp_cnt = smp_cnt + 1'b1;
                end
            end
        end
        if (pos < sdrpip_pkg::POS_MAX)
            pos = pos + 1'b1;
        if (eop) begin
            len       = {1'b0, p} + 1'b1;
            rec       = '0;
            rec.rtype = sdrpip_pkg::REC_SUMMARY;
            rec.kind  = sdrpip_pkg::KIND_UNKNOWN;
            rec.last  = 1'b1;
            if (len >= 4 && hdr_ok) begin
                case (type_code)
                    sdrpip_pkg::TYPE_DISCOVERY: rec.kind = sdrpip_pkg::KIND_DISCOVERY;
                    sdrpip_pkg::TYPE_STARTSTOP:
                        rec.kind = start_bit ? sdrpip_pkg::KIND_START : sdrpip_pkg::KIND_STOP;
                    sdrpip_pkg::TYPE_DATA:
                        rec.kind = (len >= sdrpip_pkg::PACKET_BYTES) ? sdrpip_pkg::KIND_DATA
                                                                     : sdrpip_pkg::KIND_UNKNOWN;
                    default: rec.kind = sdrpip_pkg::KIND_UNKNOWN;
                endcase
            end
            if (rec.kind == sdrpip_pkg::KIND_DATA) begin
                rec.mox   = mox_val;
                rec.freq  = freq_val;
                rec.total = smp_cnt;
            end
            expected_recs.push_back(rec);
            clear_parser();
        end
    endtask

    task automatic push_byte(input logic [7:0] b, input logic eop, input bit hold);
        pkt_beat_t bt;
        bt.data = b;
        bt.eop  = eop;
        bt.hold = hold;
        tx_bytes_q.push_back(bt);
        n_bytes++;
    endtask

    // leading bytes of a header only, for the short directed packets
    task automatic add_hdr_packet(input int len, input logic [7:0] b0, input logic [7:0] b1,
                                  input logic [7:0] b2, input logic [7:0] b3);
        logic [7:0] hb [4];
        hb[0] = b0;
        hb[1] = b1;
        hb[2] = b2;
        hb[3] = b3;
        for (int i = 0; i < len; i++)
            push_byte(hb[i], i == len - 1, 1'b0);
    endtask

    // bias toward the sample extremes 0x8000 / 0x7FFF / 0x0000 / 0xFFFF
    function automatic logic [7:0] payload_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_data_packet(input int len, input bit bad_hdr, input bit hold);
        logic [7:0] cmd [2];
        int         bad_sync [2];
        logic [7:0] b;
        int         rel;
        int         o;
        int         f;
        for (int k = 0; k < 2; k++) begin
            cmd[k] = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 9) < 6)
                cmd[k][5:1] = sdrpip_pkg::FREQ_ADDR;
            bad_sync[k] = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 2) : -1;
        end
        for (int i = 0; i < len; i++) begin
            b = payload_byte();
            if (i == 0) begin
                b = sdrpip_pkg::HDR_BYTE0;
            end else if (i == 1) begin
                b = bad_hdr ? (sdrpip_pkg::HDR_BYTE1 ^ 8'($urandom_range(1, 255)))
                            : sdrpip_pkg::HDR_BYTE1;
            end else if (i == 2) begin
                b = sdrpip_pkg::TYPE_DATA;
            end else if (i >= sdrpip_pkg::HEADER_BYTES && i < sdrpip_pkg::PACKET_BYTES) begin
                rel = i - sdrpip_pkg::HEADER_BYTES;
                f   = (rel / 512) % 2;
                o   = rel % 512;
                if (o < 3)
                    b = (o == bad_sync[f]) ?
                        (sdrpip_pkg::SYNC_BYTE ^ 8'($urandom_range(1, 255))) :
                        sdrpip_pkg::SYNC_BYTE;
                else if (o == 3)
                    b = cmd[f];
            end
            push_byte(b, i == len - 1, hold && i == 0);
        end
    endtask

    task automatic add_ctrl_packet(input int len, input bit hold);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom_range(0, 255));
            if (i == 0 && $urandom_range(0, 99) < 85) begin
                b = sdrpip_pkg::HDR_BYTE0;
            end else if (i == 1 && $urandom_range(0, 99) < 85) begin
                b = sdrpip_pkg::HDR_BYTE1;
            end else if (i == 2) begin
                case ($urandom_range(0, 3))
                    0: b = sdrpip_pkg::TYPE_DISCOVERY;
                    1: b = sdrpip_pkg::TYPE_STARTSTOP;
                    2: b = sdrpip_pkg::TYPE_DATA;
                    default: ;
                endcase
            end
            push_byte(b, i == len - 1, hold && i == 0);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            n_fail++;
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    task automatic check_beat();
        iq_rec_t rec;
        if (expected_recs.size() == 0) begin
            n_fail++;
            $display("%0t: unexpected result beat: tuser %0b tdata %h tlast %0b",
                     $time, m_tuser, m_tdata, m_tlast);
        end else begin
            rec = expected_recs.pop_front();
            check_field("record_type",    rec.rtype, m_tuser);
            check_field("packet_kind",    rec.kind,  m_tdata[2:0]);
            check_field("mox_flag",       rec.mox,   m_tdata[3]);
            check_field("frequency_word", rec.freq,  m_tdata[35:4]);
            check_field("i_sample",       rec.i_smp, m_tdata[51:36]);
            check_field("q_sample",       rec.q_smp, m_tdata[67:52]);
            check_field("sample_total",   rec.total, m_tdata[74:68]);
            check_field("tdata pad",      '0,        m_tdata[79:75]);
            check_field("last_of_run",    rec.last,  m_tlast);
        end
    endtask

    // driver: predicts on accept, then loads the next beat
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                parse_byte(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (tx_bytes_q.size() > 0 && (quiet || $urandom_range(0, 99) >= 8) &&
                    !(tx_bytes_q[0].hold && expected_recs.size() > 0)) begin
                    next_beat = tx_bytes_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_beat.data;
                    s_tlast  <= next_beat.eop;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                check_beat();
            m_tready <= quiet || ($urandom_range(0, 99) >= 8);
        end
    end

    initial begin
        int sel;
        bit hold;
        clear_parser();

        add_hdr_packet(1, sdrpip_pkg::HDR_BYTE0, 8'h00, 8'h00, 8'h00);
        add_hdr_packet(3, sdrpip_pkg::HDR_BYTE0, sdrpip_pkg::HDR_BYTE1,
                       sdrpip_pkg::TYPE_DISCOVERY, 8'h00);
        add_hdr_packet(4, sdrpip_pkg::HDR_BYTE0, sdrpip_pkg::HDR_BYTE1,
                       sdrpip_pkg::TYPE_DISCOVERY, 8'h00);
        add_hdr_packet(4, sdrpip_pkg::HDR_BYTE0, sdrpip_pkg::HDR_BYTE1,
                       sdrpip_pkg::TYPE_STARTSTOP, 8'hFF);
        add_hdr_packet(4, sdrpip_pkg::HDR_BYTE0, sdrpip_pkg::HDR_BYTE1,
                       sdrpip_pkg::TYPE_STARTSTOP, 8'hFE);
        add_hdr_packet(4, sdrpip_pkg::HDR_BYTE0, sdrpip_pkg::HDR_BYTE1,
                       sdrpip_pkg::TYPE_DATA, 8'h00);
        add_hdr_packet(4, sdrpip_pkg::HDR_BYTE0, sdrpip_pkg::HDR_BYTE1, 8'hFF, 8'h01);
        add_hdr_packet(4, 8'h00, sdrpip_pkg::HDR_BYTE1, sdrpip_pkg::TYPE_DISCOVERY, 8'h00);

        // sender holds off until the directed part has fully drained;
        // this packet also runs 1 to 40 bytes past the packet length
        add_data_packet(int'(sdrpip_pkg::PACKET_BYTES) + $urandom_range(1, 40), 1'b0, 1'b1);
        while (n_bytes < N_ITEMS) begin
            sel  = $urandom_range(0, 99);
            hold = $urandom_range(0, 99) < 5;
            if (sel < 25) begin
                add_data_packet(($urandom_range(0, 3) == 0) ? $urandom_range(121, 300) :
                                $urandom_range(1, 120), 1'b0, hold);
            end else if (sel < 35) begin
                add_data_packet($urandom_range(8, 200), 1'b1, hold);
            end else begin
                add_ctrl_packet($urandom_range(1, 48), hold);
            end
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (tx_bytes_q.size() > 0 || s_tvalid || expected_recs.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (n_fail == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #5000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- sdr_packet_iq_parser.f -----
src/sdrpip_pkg.sv
src/sdrpip_front.sv
src/sdrpip_fifo.sv
src/sdrpip_back.sv
src/sdr_packet_iq_parser.sv
tb/sv/tb.sv
